/* rtl/pwmg_pkg.sv */
// Shared types and constants for the PWM actuator peak current guard.
package pwmg_pkg;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_ABS_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TARGET_DROP = 2'd1;
    localparam logic [1:0] REG_FAST_HOLD   = 2'd2;
    localparam logic [1:0] REG_REV_COAST   = 2'd3;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [15:0] RST_ABS_LIMIT   = 16'd0;
    localparam logic [15:0] RST_TARGET_DROP = 16'd200;
    localparam logic [7:0]  RST_FAST_HOLD   = 8'd8;
    localparam logic [7:0]  RST_REV_COAST   = 8'd2;

    // Sign codes
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // Decay modes on the output
    localparam logic [1:0] MODE_COAST = 2'd0;
    localparam logic [1:0] MODE_SLOW  = 2'd2;
    localparam logic [1:0] MODE_FAST  = 2'd3;

    // Decay selection codes on a command
    localparam logic [7:0] SEL_FIXED_LO = 8'd1;
    localparam logic [7:0] SEL_FIXED_HI = 8'd3;
    localparam logic [7:0] SEL_AUTO     = 8'd4;

    localparam logic signed [15:0] PWM_MAX = 16'sd1000;
    localparam logic signed [15:0] PWM_MIN = -16'sd1000;

    localparam logic [15:0] CHOP_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] peak_limit_ma;
        logic [15:0] target_drop_ma;
        logic [7:0]  fast_hold_cycles;
        logic [7:0]  flip_coast_cycles;
    } cfg_t;

endpackage

/* rtl/pwmg_regs.sv */
// APB configuration registers of the peak current guard.
module pwmg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwmg_pkg::ADDR_W-1:0] paddr,
    input  logic [pwmg_pkg::DATA_W-1:0] pwdata,
    output logic [pwmg_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pwmg_pkg::cfg_t              cfg
);

    pwmg_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_limit_ma     <= pwmg_pkg::RST_ABS_LIMIT;
            cfg_reg.target_drop_ma    <= pwmg_pkg::RST_TARGET_DROP;
            cfg_reg.fast_hold_cycles  <= pwmg_pkg::RST_FAST_HOLD;
            cfg_reg.flip_coast_cycles <= pwmg_pkg::RST_REV_COAST;
        end else if (wr_en) begin
            unique case (idx)
                pwmg_pkg::REG_ABS_LIMIT:   cfg_reg.peak_limit_ma     <= pwdata[15:0];
                pwmg_pkg::REG_TARGET_DROP: cfg_reg.target_drop_ma    <= pwdata[15:0];
                pwmg_pkg::REG_FAST_HOLD:   cfg_reg.fast_hold_cycles  <= pwdata[7:0];
                pwmg_pkg::REG_REV_COAST:   cfg_reg.flip_coast_cycles <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pwmg_pkg::REG_ABS_LIMIT:   prdata = {16'd0, cfg_reg.peak_limit_ma};
            pwmg_pkg::REG_TARGET_DROP: prdata = {16'd0, cfg_reg.target_drop_ma};
            pwmg_pkg::REG_FAST_HOLD:   prdata = {24'd0, cfg_reg.fast_hold_cycles};
            pwmg_pkg::REG_REV_COAST:   prdata = {24'd0, cfg_reg.flip_coast_cycles};
            default:                   prdata = '0;
        endcase
    end

endmodule

/* rtl/pwm_actuator_peak_current_guard.sv */
// Top level of the PWM actuator with synchronous peak current guard.
//
//  channel | direction | handshake          | word carries
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready  | command or PWM-cycle item
//  m_      | out       | m_valid / m_ready  | duty, decay mode, hard limit, chop count
//  apb     | in        | psel/penable/pready| four configuration registers
//
//  One word per clock while m_ready keeps up: the whole step is one pass of compare
//  and counter logic between the runtime state registers and the result register.
//  Each accepted word yields exactly one result word, held in the result register.
//  s_ready is high while the result register is empty or being drained, so a
//  stalled m_ready holds the input only once the result register is full.
//  aresetn (synchronous, active low) clears the runtime state, the chop count
//  and the result valid flag, and loads the register reset values.
module pwm_actuator_peak_current_guard (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic                        s_enable,
    input  logic signed [15:0]          s_target_current_ma,
    input  logic signed [15:0]          s_feedforward_pwm,
    input  logic [7:0]                  s_pwm_mode_select,
    input  logic signed [15:0]          s_measured_current_ma,
    input  logic                        s_sample_valid,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [10:0]          m_duty_permille,
    output logic [1:0]                  m_decay_mode,
    output logic                        m_hard_limit,
    output logic [15:0]                 m_chop_event_count,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwmg_pkg::ADDR_W-1:0] paddr,
    input  logic [pwmg_pkg::DATA_W-1:0] pwdata,
    output logic [pwmg_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    pwmg_pkg::cfg_t cfg;

    pwmg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Runtime state; the feedforward is kept already clamped to +-1000.
    logic               en_reg,    en_next;
    logic signed [10:0] ff_reg,    ff_next;
    logic [7:0]         sel_reg,   sel_next;
    logic [1:0]         pts_reg,   pts_next;
    logic [15:0]        ptm_reg,   ptm_next;
    logic [1:0]         pvs_reg,   pvs_next;
    logic [7:0]         coast_reg, coast_next;
    logic [7:0]         hold_reg,  hold_next;
    logic [15:0]        chop_reg,  chop_next;

    // Result register
    logic               m_valid_reg;
    logic signed [10:0] power_reg, power_next;
    logic [1:0]         dmode_reg, dmode_next;
    logic               hard_reg,  hard_next;
    logic [15:0]        count_reg;

    logic               in_fire;
    logic [15:0]        tgt_mag;
    logic [1:0]         tgt_sign;
    logic [16:0]        drop_sum;
    logic signed [10:0] ff_clamped;
    logic [15:0]        meas_mag;
    logic [1:0]         vs;
    logic [7:0]         coast_work;
    logic               trip;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    assign m_valid            = m_valid_reg;
    assign m_duty_permille    = power_reg;
    assign m_decay_mode       = dmode_reg;
    assign m_hard_limit       = hard_reg;
    assign m_chop_event_count = count_reg;

    // Magnitudes fit 16 unsigned bits: minus 32768 negates to 0x8000.
    assign tgt_mag  = s_target_current_ma[15] ? 16'(-s_target_current_ma)
                                              : 16'(s_target_current_ma);
    assign meas_mag = s_measured_current_ma[15] ? 16'(-s_measured_current_ma)
                                                : 16'(s_measured_current_ma);
    assign tgt_sign = s_target_current_ma[15] ? pwmg_pkg::SIGN_NEG : pwmg_pkg::SIGN_POS;
    assign drop_sum = {1'b0, tgt_mag} + {1'b0, cfg.target_drop_ma};

    always_comb begin
        if (s_feedforward_pwm > pwmg_pkg::PWM_MAX) begin
            ff_clamped = 11'(pwmg_pkg::PWM_MAX);
        end else if (s_feedforward_pwm < pwmg_pkg::PWM_MIN) begin
            ff_clamped = 11'(pwmg_pkg::PWM_MIN);
        end else begin
            ff_clamped = s_feedforward_pwm[10:0];
        end
    end

    assign vs = (ff_reg > 11'sd0) ? pwmg_pkg::SIGN_POS :
                (ff_reg < 11'sd0) ? pwmg_pkg::SIGN_NEG : pwmg_pkg::SIGN_NONE;

    // Reversal rearms the coast counter before the guard and coast checks.
    assign coast_work = (pvs_reg != pwmg_pkg::SIGN_NONE && vs != pwmg_pkg::SIGN_NONE &&
                         vs != pvs_reg) ? cfg.flip_coast_cycles : coast_reg;

    assign trip = s_sample_valid && (cfg.peak_limit_ma != 16'd0) &&
                  (meas_mag >= cfg.peak_limit_ma);

    always_comb begin
        en_next    = en_reg;
        ff_next    = ff_reg;
        sel_next   = sel_reg;
        pts_next   = pts_reg;
        ptm_next   = ptm_reg;
        pvs_next   = pvs_reg;
        coast_next = coast_reg;
        hold_next  = hold_reg;
        chop_next  = chop_reg;
        power_next = '0;
        dmode_next = pwmg_pkg::MODE_COAST;
        hard_next  = 1'b0;

        if (s_mode) begin
            if (!s_enable || s_target_current_ma == 16'sd0) begin
                // Disable: drop the runtime state, keep the decay selection.
                en_next    = 1'b0;
                ff_next    = '0;
                pts_next   = pwmg_pkg::SIGN_NONE;
                ptm_next   = '0;
                pvs_next   = pwmg_pkg::SIGN_NONE;
                coast_next = '0;
                hold_next  = '0;
            end else begin
                if (s_pwm_mode_select == pwmg_pkg::SEL_AUTO) begin
                    // Sign flip or large drop arms the fast hold, not on first enable.
                    if (en_reg && ((pts_reg != pwmg_pkg::SIGN_NONE && tgt_sign != pts_reg) ||
                                   {1'b0, ptm_reg} >= drop_sum)) begin
                        hold_next = cfg.fast_hold_cycles;
                    end
                end else begin
                    hold_next = '0;
                end
                ff_next  = ff_clamped;
                sel_next = s_pwm_mode_select;
                pts_next = tgt_sign;
                ptm_next = tgt_mag;
                en_next  = 1'b1;
            end
        end else if (!en_reg) begin
            pts_next   = pwmg_pkg::SIGN_NONE;
            ptm_next   = '0;
            pvs_next   = pwmg_pkg::SIGN_NONE;
            coast_next = '0;
            hold_next  = '0;
        end else begin
            if (vs != pwmg_pkg::SIGN_NONE) begin
                pvs_next = vs;
            end
            coast_next = coast_work;
            if (trip) begin
                // Coast this cycle, flag it and bump the saturating chop count.
                if (chop_reg != pwmg_pkg::CHOP_MAX) begin
                    chop_next = chop_reg + 16'd1;
                end
                hard_next = 1'b1;
            end else if (coast_work != 8'd0) begin
                coast_next = coast_work - 8'd1;
            end else begin
                if (sel_reg >= pwmg_pkg::SEL_FIXED_LO && sel_reg <= pwmg_pkg::SEL_FIXED_HI) begin
                    dmode_next = sel_reg[1:0];
                end else if (sel_reg == pwmg_pkg::SEL_AUTO && hold_reg != 8'd0) begin
                    hold_next  = hold_reg - 8'd1;
                    dmode_next = pwmg_pkg::MODE_FAST;
                end else begin
                    dmode_next = pwmg_pkg::MODE_SLOW;
                end
                // Zero duty coasts, the hold still counts down.
                if (ff_reg == 11'sd0) begin
                    dmode_next = pwmg_pkg::MODE_COAST;
                end
                power_next = ff_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= 1'b0;
            ff_reg    <= '0;
            sel_reg   <= pwmg_pkg::SEL_AUTO;
            pts_reg   <= pwmg_pkg::SIGN_NONE;
            ptm_reg   <= '0;
            pvs_reg   <= pwmg_pkg::SIGN_NONE;
            coast_reg <= '0;
            hold_reg  <= '0;
            chop_reg  <= '0;
        end else if (in_fire) begin
            en_reg    <= en_next;
            ff_reg    <= ff_next;
            sel_reg   <= sel_next;
            pts_reg   <= pts_next;
            ptm_reg   <= ptm_next;
            pvs_reg   <= pvs_next;
            coast_reg <= coast_next;
            hold_reg  <= hold_next;
            chop_reg  <= chop_next;
        end
    end

    // Load the result word on accept, release it once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            power_reg <= power_next;
            dmode_reg <= dmode_next;
            hard_reg  <= hard_next;
            count_reg <= chop_next;
        end
    end

    // Every accepted word shows up as a result on the next cycle.
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid_reg)
        else $error("accepted word produced no result");

    // A command word always returns zero drive with no trip.
    a_cmd_zero_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_mode |=> power_reg == 11'sd0 &&
                              dmode_reg == pwmg_pkg::MODE_COAST && !hard_reg)
        else $error("command word returned drive");

    // A guard trip never drives the bridge.
    a_trip_coasts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && hard_reg |-> power_reg == 11'sd0 &&
                                    dmode_reg == pwmg_pkg::MODE_COAST)
        else $error("hard limit with nonzero drive");

    // While disabled the runtime counters and signs stay cleared.
    a_disabled_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !en_reg |-> coast_reg == 8'd0 && hold_reg == 8'd0 &&
                    pvs_reg == pwmg_pkg::SIGN_NONE && pts_reg == pwmg_pkg::SIGN_NONE)
        else $error("runtime state not cleared while disabled");

    // The chop count never goes down outside reset.
    a_chop_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> chop_reg >= $past(chop_reg))
        else $error("chop count decreased");

endmodule
